@@ rtl/delay_line_pitch_shifter_macros.svh @@
// Assertion helpers for the RTL file that carries checks.
`ifndef DELAY_LINE_PITCH_SHIFTER_MACROS_SVH
`define DELAY_LINE_PITCH_SHIFTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DLPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DLPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/dlps_pkg.sv @@
package dlps_pkg;

	localparam int MIC_W    = 32;
	localparam int SPK_W    = 16;
	localparam int GAIN_W   = 8;
	localparam int STEP_W   = 10;
	localparam int RING_W   = 18;
	localparam int WGT_W    = 16;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_STEP = CFG_IDX_W'(1);

	localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd40;
	localparam logic [STEP_W-1:0] STEP_RESET = 10'd384;
	localparam logic [STEP_W-1:0] UNITY_STEP = 10'd256;

	localparam int Q15_ONE  = 32768;
	localparam int RING_MAX = 131071;
	localparam int RING_MIN = -131072;
	localparam int SPK_MAX  = 32767;
	localparam int SPK_MIN  = -32768;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_RD0,
		ST_RD1,
		ST_MUL,
		ST_OUT
	} dlps_state_t;

	typedef enum logic [2:0] {
		FM_KEEP,
		FM_ZERO,
		FM_ONE,
		FM_RAMP0,
		FM_RAMP1
	} fade_mode_t;

	typedef struct packed {
		logic mul_en;
		logic upd_en;
	} fade_ctl_t;

endpackage

@@ rtl/dlps_if.sv @@
interface dlps_mic_if;
	logic                               valid;
	logic                               ready;
	logic signed [dlps_pkg::MIC_W-1:0]  mic_word;

	modport source (output valid, output mic_word, input ready);
	modport sink (input valid, input mic_word, output ready);
endinterface

interface dlps_spk_if;
	logic                               valid;
	logic                               ready;
	logic signed [dlps_pkg::SPK_W-1:0]  out_sample;

	modport source (output valid, output out_sample, input ready);
	modport sink (input valid, input out_sample, output ready);
endinterface

interface dlps_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [dlps_pkg::CFG_IDX_W-1:0]      index;
	logic [dlps_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/delay_line_pitch_shifter.sv @@
// Each sample runs a fixed sequence of one ring write, two ring reads through the
// single read port, the tap multiply and the final sum; a new sample is taken only
// when the last leaves OUT. A stalled output beat holds the sequence in OUT until it drains.
// Reset: registers return to their defaults (gain 2.5, step 1.5, weight 1.0), and
// the pointers clear. The ring is not swept; a fill flag makes unwritten entries read zero.
`include "delay_line_pitch_shifter_macros.svh"

module delay_line_pitch_shifter #(
	parameter int RING_DEPTH = 256,
	parameter int FADE_SPAN  = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	dlps_cfg_if.sink    cfg,
	dlps_mic_if.sink    mic,
	dlps_spk_if.source  spk
);
	import dlps_pkg::*;

	localparam int AW   = $clog2(RING_DEPTH);
	localparam int DW   = $clog2(FADE_SPAN + 1);
	localparam int DXW  = (AW > DW) ? AW : DW;
	// The read position stays below RING_DEPTH entries in Q8.
	localparam int RPW  = AW + 8;
	localparam int NXW  = RPW + 2;
	localparam int RNW  = NXW - 8;
	localparam int HALF = RING_DEPTH / 2;

	// Configuration registers. Writes are always taken.
	logic [GAIN_W-1:0] gain_q;
	logic [STEP_W-1:0] step_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			step_q <= STEP_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_INPUT_GAIN: gain_q <= cfg.data[GAIN_W-1:0];
				REG_SHIFT_STEP: step_q <= cfg.data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer. Each sample walks ADDR, RD0, RD1, MUL and OUT. The next sample
	// can be taken in the same cycle OUT hands its result to the output register.
	dlps_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;
	logic        in_acc;
	logic        mem_we;
	logic        rd_sel_r1;
	fade_ctl_t   fade_ctl;
	logic        ld_addr, ld_tap0, ld_prod, ld_out;

	assign out_free = !out_valid_q || spk.ready;
	assign in_acc   = mic.valid && mic.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (mic.valid) state_d = ST_ADDR;
			ST_ADDR: state_d = ST_RD0;
			ST_RD0:  state_d = ST_RD1;
			ST_RD1:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = mic.valid ? ST_ADDR : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mic.ready       = 1'b0;
		mem_we          = 1'b0;
		rd_sel_r1       = 1'b0;
		fade_ctl.mul_en = 1'b0;
		fade_ctl.upd_en = 1'b0;
		ld_addr         = 1'b0;
		ld_tap0         = 1'b0;
		ld_prod         = 1'b0;
		ld_out          = 1'b0;
		case (state_q)
			ST_IDLE: mic.ready = 1'b1;
			ST_ADDR: begin
				mem_we  = 1'b1;
				ld_addr = 1'b1;
			end
			ST_RD0:  fade_ctl.mul_en = 1'b1;
			ST_RD1: begin
				rd_sel_r1       = 1'b1;
				ld_tap0         = 1'b1;
				fade_ctl.upd_en = 1'b1;
			end
			ST_MUL:  ld_prod = 1'b1;
			ST_OUT: begin
				mic.ready = out_free;
				ld_out    = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Upper half of the microphone word is the 16-bit sample.
	logic signed [15:0] s_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s_q <= mic.mic_word[MIC_W-1 -: 16];
		end
	end

	// Gain stage: Q4 multiply, divide by 16 toward zero, clamp to 18 bits.
	logic signed [24:0]       gprod;
	logic signed [24:0]       gadj;
	logic signed [24:0]       gq;
	logic signed [RING_W-1:0] ring_in;

	assign gprod = s_q * $signed({1'b0, gain_q});
	assign gadj  = gprod + (gprod[24] ? 25'sd15 : 25'sd0);
	assign gq    = gadj >>> 4;

	always_comb begin
		if (gq > 25'(RING_MAX)) begin
			ring_in = RING_W'(RING_MAX);
		end else if (gq < 25'(RING_MIN)) begin
			ring_in = RING_W'(RING_MIN);
		end else begin
			ring_in = gq[RING_W-1:0];
		end
	end

	// Write index, fill flag and read position. An entry above the write index
	// has never been written until the index first wraps.
	logic [AW-1:0]  wi_q;
	logic           full_q;
	logic [RPW-1:0] rp_q;

	// Tap addresses from the rounded read position.
	logic [RNW-1:0] rnd;
	logic [AW-1:0]  r0;
	logic [AW:0]    r1x;
	logic [AW-1:0]  r1;

	assign rnd = RNW'((NXW'(rp_q) + NXW'(128)) >> 8);
	assign r0  = (rnd >= RNW'(RING_DEPTH)) ? '0 : rnd[AW-1:0];

	always_comb begin
		if ((AW+1)'(r0) >= (AW+1)'(HALF)) begin
			r1x = (AW+1)'(r0) - (AW+1)'(HALF);
		end else begin
			r1x = (AW+1)'(r0) + (AW+1)'(HALF);
		end
	end

	assign r1 = (r1x >= (AW+1)'(RING_DEPTH)) ? '0 : r1x[AW-1:0];

	// Fade decision. A tap whose distance behind the write index lies within
	// the fade span sets a ramp weight unless the step is unity; a tap landing
	// exactly on the write index snaps the weight. Tap 1 takes priority.
	logic          ramp;
	logic [AW-1:0] diff0, diff1;
	logic          in0, in1, hit0, hit1;
	fade_mode_t    mode_d, mode_q;
	logic [DW-1:0] dsel_d, dsel_q;
	logic [AW-1:0] r0_q, r1_q;

	assign ramp  = (step_q != UNITY_STEP);
	assign diff0 = wi_q - r0;
	assign diff1 = wi_q - r1;
	assign hit0  = (wi_q == r0);
	assign hit1  = (wi_q == r1);
	assign in0   = ramp && (wi_q >= r0) && (DXW'(diff0) <= DXW'(FADE_SPAN));
	assign in1   = ramp && (wi_q >= r1) && (DXW'(diff1) <= DXW'(FADE_SPAN));

	always_comb begin
		mode_d = FM_KEEP;
		dsel_d = '0;
		if (in1) begin
			mode_d = FM_RAMP1;
			dsel_d = DW'(diff1);
		end else if (hit1) begin
			mode_d = FM_ONE;
		end else if (in0) begin
			mode_d = FM_RAMP0;
			dsel_d = DW'(diff0);
		end else if (hit0) begin
			mode_d = FM_ZERO;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_addr) begin
			r0_q   <= r0;
			r1_q   <= r1;
			dsel_q <= dsel_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= FM_KEEP;
		end else if (ld_addr) begin
			mode_q <= mode_d;
		end
	end

	// Crossfade weight: reciprocal divide over RD0 and RD1, ready by MUL.
	logic [WGT_W-1:0] fade_w;

	dlps_fade #(
		.FADE_SPAN (FADE_SPAN)
	) u_fade (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fade_ctl),
		.mode   (mode_q),
		.d      (dsel_q),
		.weight (fade_w)
	);

	// Ring memory. The new sample is written in ADDR, so both later reads
	// already see it and no forwarding is needed.
	logic signed [RING_W-1:0] ring_mem [RING_DEPTH];
	logic signed [RING_W-1:0] rd_q;
	logic [AW-1:0]            rd_addr;

	assign rd_addr = rd_sel_r1 ? r1_q : r0_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[wi_q] <= ring_in;
		end
		rd_q <= ring_mem[rd_addr];
	end

	logic                     blank0, blank1;
	logic signed [RING_W-1:0] tap0_q;
	logic signed [RING_W-1:0] tap1;

	assign blank0 = !full_q && (r0_q > wi_q);
	assign blank1 = !full_q && (r1_q > wi_q);
	assign tap1   = blank1 ? '0 : rd_q;

	always_ff @(posedge clk) begin
		if (ld_tap0) begin
			tap0_q <= blank0 ? '0 : rd_q;
		end
	end

	// Weighted taps: two 18x17 products, summed in OUT.
	logic [WGT_W:0]               wcomp;
	logic signed [RING_W+WGT_W:0] p0_q, p1_q;

	assign wcomp = (WGT_W+1)'(Q15_ONE) - {1'b0, fade_w};

	always_ff @(posedge clk) begin
		if (ld_prod) begin
			p0_q <= tap0_q * $signed({1'b0, fade_w});
			p1_q <= tap1 * $signed(wcomp);
		end
	end

	// Sum, divide by 2^15 toward zero, saturate to 16 bits.
	localparam int SW = RING_W + WGT_W + 2;

	logic signed [SW-1:0]    sum;
	logic signed [SW-1:0]    sadj;
	logic signed [SW-1:0]    sq;
	logic signed [SPK_W-1:0] sat;

	assign sum  = SW'(p0_q) + SW'(p1_q);
	assign sadj = sum + (sum[SW-1] ? SW'(32767) : SW'(0));
	assign sq   = sadj >>> 15;

	always_comb begin
		if (sq > SW'(SPK_MAX)) begin
			sat = SPK_W'(SPK_MAX);
		end else if (sq < SW'(SPK_MIN)) begin
			sat = SPK_W'(SPK_MIN);
		end else begin
			sat = sq[SPK_W-1:0];
		end
	end

	// Read position advances by the step; once its rounded value reaches the
	// ring end it restarts at zero.
	logic [NXW-1:0] rp_nx;
	logic [RNW-1:0] rnd_nx;

	assign rp_nx  = NXW'(rp_q) + NXW'(step_q);
	assign rnd_nx = RNW'((rp_nx + NXW'(128)) >> 8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q   <= '0;
			full_q <= 1'b0;
			rp_q   <= '0;
		end else if (ld_out) begin
			if (wi_q == AW'(RING_DEPTH - 1)) begin
				wi_q   <= '0;
				full_q <= 1'b1;
			end else begin
				wi_q <= wi_q + 1'b1;
			end
			if (rnd_nx >= RNW'(RING_DEPTH)) begin
				rp_q <= '0;
			end else begin
				rp_q <= rp_nx[RPW-1:0];
			end
		end
	end

	// Output register: holds one finished beat while the next sample runs.
	logic signed [SPK_W-1:0] out_sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (spk.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_sample_q <= sat;
		end
	end

	assign spk.valid      = out_valid_q;
	assign spk.out_sample = out_sample_q;

	// Checks.
	`DLPS_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_acc, state_q == ST_ADDR, "accepted beat did not start the sequence")
	`DLPS_ASSERT_NOW(a_rnd_in_ring, clk, arst_n, state_q == ST_ADDR, rnd < RNW'(RING_DEPTH), "rounded read position left the ring")
	`DLPS_ASSERT_NOW(a_weight_range, clk, arst_n, 1'b1, fade_w <= WGT_W'(Q15_ONE), "fade weight above one")
	`DLPS_ASSERT_NEXT(a_wi_hold, clk, arst_n, !ld_out, $stable(wi_q) && $stable(rp_q), "pointers moved outside the output step")

endmodule

@@ rtl/dlps_fade.sv @@
module dlps_fade #(
	parameter int FADE_SPAN = 100
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dlps_pkg::fade_ctl_t               ctl,
	input  dlps_pkg::fade_mode_t              mode,
	input  logic [$clog2(FADE_SPAN+1)-1:0]    d,
	output logic [dlps_pkg::WGT_W-1:0]        weight
);
	import dlps_pkg::*;

	localparam int DW       = $clog2(FADE_SPAN + 1);
	localparam int RECIP_SH = 27;
	localparam int RECIP_W  = RECIP_SH + 1;
	localparam int MW       = DW + RECIP_W;
	localparam int PW       = WGT_W + DW;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / FADE_SPAN);

	logic [MW-1:0]    prod;
	logic [WGT_W-1:0] q_est_q;
	logic [DW-1:0]    d_q;
	fade_mode_t       mode_q;
	logic [PW-1:0]    num;
	logic [PW-1:0]    qf;
	logic [PW-1:0]    rem;
	logic [WGT_W-1:0] quot;
	logic [WGT_W-1:0] weight_q;

	// d * 2^15 / FADE_SPAN by reciprocal; the estimate is low by at most one.
	assign prod = MW'(d) * MW'(RECIP);

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			q_est_q <= prod[RECIP_SH-15 +: WGT_W];
			d_q     <= d;
			mode_q  <= mode;
		end
	end

	assign num  = PW'({d_q, 15'b0});
	assign qf   = PW'(q_est_q) * PW'(FADE_SPAN);
	assign rem  = num - qf;
	assign quot = (rem >= PW'(FADE_SPAN)) ? WGT_W'(q_est_q + 1'b1) : q_est_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WGT_W'(Q15_ONE);
		end else if (ctl.upd_en) begin
			case (mode_q)
				FM_ZERO:  weight_q <= '0;
				FM_ONE:   weight_q <= WGT_W'(Q15_ONE);
				FM_RAMP0: weight_q <= quot;
				FM_RAMP1: weight_q <= WGT_W'(Q15_ONE) - quot;
				default:  weight_q <= weight_q;
			endcase
		end
	end

	assign weight = weight_q;

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dlps_pkg::*;

	// The block is built with its default geometry; the predictor uses the same values.
	localparam int RING_DEPTH = 256;
	localparam int FADE_SPAN  = 100;

	// The pause before a register write and the tail at the end only have to cover
	// the block's own sequence for one sample. The watchdog limit covers the longest
	// quiet stretch of a correct run by a wide margin. That stretch is the longest
	// sender gap, the block's own sequence, the longest receiver stall and the pause
	// between phases.
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SIDE_MIC       = 0;
	localparam int SIDE_SPK       = 1;

	typedef struct {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n;

	dlps_cfg_if cfg_if ();
	dlps_mic_if mic_if ();
	dlps_spk_if spk_if ();

	delay_line_pitch_shifter #(
		.RING_DEPTH (RING_DEPTH),
		.FADE_SPAN  (FADE_SPAN)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.mic    (mic_if),
		.spk    (spk_if)
	);

	always #5 clk = ~clk;

	// Stimulus waiting to be driven, and the samples the block owes us, oldest first.
	logic [MIC_W-1:0]        pending_words[$];
	reg_write_t              pending_writes[$];
	logic signed [SPK_W-1:0] expected_samples[$];

	// Our own copy of the shifter: registers, pointers, crossfade weight and ring.
	int gain_q4;
	int step_q8;
	int wr_idx;
	int rd_pos;
	int fade_w;
	int shift_ring[RING_DEPTH];

	int error_count;
	int quiet_cycles;
	int calm_left[2];
	int mic_gap_left;
	int spk_stall_left;
	logic mic_next_valid;
	logic cfg_next_valid;
	logic spk_next_ready;

	function automatic void reset_shifter_model();
		gain_q4 = int'(GAIN_RESET);
		step_q8 = int'(STEP_RESET);
		wr_idx  = 0;
		rd_pos  = 0;
		fade_w  = Q15_ONE;
		foreach (shift_ring[i])
			shift_ring[i] = 0;
	endfunction

	// Works out the speaker sample for one microphone word and advances the model.
	function automatic logic signed [SPK_W-1:0] predict_shifted_sample(logic [MIC_W-1:0] word);
		longint scaled;
		longint tap_sum;
		longint mixed;
		int near_idx;
		int far_idx;
		int lag0;
		int lag1;
		bit ramp_on;

		// Keep the upper half as a signed sample and apply the Q4 gain. The
		// division truncates toward zero, then the result is clamped to 18 bits.
		scaled = longint'(signed'(word[MIC_W-1:MIC_W-SPK_W])) * longint'(gain_q4);
		scaled = scaled / 16;
		if (scaled > RING_MAX)
			scaled = RING_MAX;
		else if (scaled < RING_MIN)
			scaled = RING_MIN;
		shift_ring[wr_idx] = int'(scaled);

		// The two taps sit half a ring apart around the rounded read pointer.
		near_idx = (rd_pos + 128) >>> 8;
		if (near_idx >= RING_DEPTH)
			near_idx = 0;
		far_idx = (near_idx >= RING_DEPTH / 2) ? near_idx - RING_DEPTH / 2
			: near_idx + RING_DEPTH / 2;

		// The weight ramps while the write index is just ahead of a tap. At unity
		// step it only jumps when a tap lands exactly on the write index.
		lag0 = wr_idx - near_idx;
		lag1 = wr_idx - far_idx;
		ramp_on = (step_q8 != int'(UNITY_STEP));
		if (ramp_on && lag0 >= 0 && lag0 <= FADE_SPAN)
			fade_w = (lag0 * Q15_ONE) / FADE_SPAN;
		else if (lag0 == 0)
			fade_w = 0;
		if (ramp_on && lag1 >= 0 && lag1 <= FADE_SPAN)
			fade_w = Q15_ONE - (lag1 * Q15_ONE) / FADE_SPAN;
		else if (lag1 == 0)
			fade_w = Q15_ONE;

		tap_sum = longint'(shift_ring[near_idx]) * longint'(fade_w)
			+ longint'(shift_ring[far_idx]) * longint'(Q15_ONE - fade_w);
		mixed = tap_sum / Q15_ONE;
		if (mixed > SPK_MAX)
			mixed = SPK_MAX;
		else if (mixed < SPK_MIN)
			mixed = SPK_MIN;

		// The read pointer is kept wider than 16 bits, so the wrap test after the
		// step sees the true sum.
		rd_pos = rd_pos + step_q8;
		wr_idx = (wr_idx + 1) % RING_DEPTH;
		if (((rd_pos + 128) >>> 8) >= RING_DEPTH)
			rd_pos = 0;
		return mixed[SPK_W-1:0];
	endfunction

	// Each side draws a random idle gap per beat. Now and then a calm stretch runs
	// with no waiting at all, so that back-to-back beats are covered too.
	function automatic int idle_cycles(int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 11) == 0)
			calm_left[side] = $urandom_range(10, 40);
		return $urandom_range(0, 16);
	endfunction

	// Microphone words are biased toward the ends of the 16-bit sample range, so that
	// gain saturation and output saturation occur often, and toward zero. Plain random
	// words still toggle every bit of the field.
	function automatic logic [MIC_W-1:0] random_mic_word();
		logic [MIC_W-1:0] word;
		word = $urandom;
		case ($urandom_range(0, 4))
			0: word[31:16] = 16'(32'h7F00 + $urandom_range(0, 255));
			1: word[31:16] = 16'(32'h8000 + $urandom_range(0, 255));
			2: word[31:16] = 16'($urandom_range(0, 511) - 256);
			default: ;
		endcase
		return word;
	endfunction

	// Config driver. A write beat updates the model's registers at the edge where
	// it is accepted. The stimulus only writes while the block is idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_if.valid <= 1'b0;
			cfg_if.index <= '0;
			cfg_if.data  <= '0;
		end else begin
			cfg_next_valid = cfg_if.valid;
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.index)
					REG_INPUT_GAIN: gain_q4 = int'(cfg_if.data[GAIN_W-1:0]);
					REG_SHIFT_STEP: step_q8 = int'(cfg_if.data[STEP_W-1:0]);
					default: ;
				endcase
				cfg_next_valid = 1'b0;
			end
			if (!cfg_next_valid && pending_writes.size() > 0) begin
				cfg_if.index <= pending_writes[0].index;
				cfg_if.data  <= pending_writes[0].data;
				void'(pending_writes.pop_front());
				cfg_next_valid = 1'b1;
			end
			cfg_if.valid <= cfg_next_valid;
		end
	end

	// Microphone driver. Each accepted beat is run through the predictor at
	// once. The next word goes out after its idle gap. Valid is assigned only once
	// per edge, so it stays high across back-to-back beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mic_if.valid    <= 1'b0;
			mic_if.mic_word <= '0;
			mic_gap_left    = 0;
		end else begin
			mic_next_valid = mic_if.valid;
			if (mic_if.valid && mic_if.ready) begin
				expected_samples.push_back(predict_shifted_sample(mic_if.mic_word));
				mic_next_valid = 1'b0;
			end
			if (!mic_next_valid) begin
				if (mic_gap_left > 0) begin
					mic_gap_left--;
				end else if (pending_words.size() > 0) begin
					mic_if.mic_word <= pending_words.pop_front();
					mic_next_valid = 1'b1;
					mic_gap_left = idle_cycles(SIDE_MIC);
				end
			end
			mic_if.valid <= mic_next_valid;
		end
	end

	// Speaker monitor. It compares every accepted beat with the oldest expected
	// sample, then stalls ready for a random number of cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spk_if.ready   <= 1'b0;
			spk_stall_left = 0;
		end else begin
			spk_next_ready = spk_if.ready;
			if (spk_if.valid && spk_if.ready) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: speaker beat %0d arrived with no sample expected",
						$time, spk_if.out_sample);
					error_count++;
				end else if (spk_if.out_sample !== expected_samples[0]) begin
					$display("%0t: out_sample mismatch, expected %0d, actual %0d",
						$time, expected_samples[0], spk_if.out_sample);
					error_count++;
					void'(expected_samples.pop_front());
				end else begin
					void'(expected_samples.pop_front());
				end
				spk_stall_left = idle_cycles(SIDE_SPK);
				spk_next_ready = (spk_stall_left == 0);
			end else if (!spk_if.ready) begin
				if (spk_stall_left > 0)
					spk_stall_left--;
				spk_next_ready = (spk_stall_left == 0);
			end
			spk_if.ready <= spk_next_ready;
		end
	end

	// Watchdog. It counts cycles in which no channel moves a beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cfg_if.valid && cfg_if.ready) || (mic_if.valid && mic_if.ready)
				|| (spk_if.valid && spk_if.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: no beat for %0d cycles", $time, quiet_cycles);
					$display("TEST FAILED");
					$finish;
				end
			end
		end
	end

	// The sender holds back until every word is out and every sample has come
	// back. It then waits out SETTLE_CYCLES, so that the block is idle for a
	// register write.
	task automatic drain_block();
		while (pending_words.size() > 0 || mic_if.valid || expected_samples.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_settings(int gain, int step);
		reg_write_t wr;
		wr.index = REG_INPUT_GAIN;
		wr.data  = CFG_DATA_W'(gain);
		pending_writes.push_back(wr);
		wr.index = REG_SHIFT_STEP;
		wr.data  = CFG_DATA_W'(step);
		pending_writes.push_back(wr);
		while (pending_writes.size() > 0 || cfg_if.valid)
			@(posedge clk);
	endtask

	task automatic queue_random_words(int count);
		repeat (count) pending_words.push_back(random_mic_word());
	endtask

	// Words at the ends of the sample range, near zero and at half scale, plus the
	// low-half bits, which the block must ignore.
	task automatic queue_extreme_words();
		pending_words.push_back(32'h7FFF_FFFF);
		pending_words.push_back(32'h8000_0000);
		pending_words.push_back(32'h0000_0000);
		pending_words.push_back(32'hFFFF_FFFF);
		pending_words.push_back(32'h0000_FFFF);
		pending_words.push_back(32'hFFFF_0000);
		pending_words.push_back(32'h0001_0000);
		pending_words.push_back(32'h7FFF_0000);
		pending_words.push_back(32'h8001_8000);
		pending_words.push_back(32'h4000_1234);
		pending_words.push_back(32'hC000_0001);
		pending_words.push_back(32'h7FFF_FFFF);
	endtask

	initial begin
		int gain;
		int step;

		arst_n          = 1'b0;
		error_count     = 0;
		quiet_cycles    = 0;
		calm_left[SIDE_MIC] = 0;
		calm_left[SIDE_SPK] = 0;
		reset_shifter_model();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// First, the defaults from reset. The unwritten ring still reads as zeros, and
		// full-scale words at gain 2.5 stay below the limit of the stored samples.
		queue_extreme_words();
		drain_block();

		// Full gain with a frozen read pointer: the ring saturates, the output
		// saturates, and the weight ramps as the write index sweeps past the taps.
		write_settings(255, 0);
		queue_extreme_words();
		queue_random_words(50);
		drain_block();

		// Zero gain at the fastest step, so that the read pointer wraps quickly.
		write_settings(0, 1023);
		queue_random_words(50);
		drain_block();

		// Unity gain at unity step: the ramps are off, and the weight only flips
		// when a tap lands exactly on the write index.
		write_settings(16, int'(UNITY_STEP));
		queue_random_words(120);
		drain_block();

		write_settings(int'(GAIN_RESET), int'(STEP_RESET));
		queue_random_words(120);
		drain_block();

		// Steps just around unity and the smallest nonzero step.
		write_settings(255, 1);
		queue_random_words(60);
		drain_block();

		write_settings(128, int'(UNITY_STEP) - 1);
		queue_random_words(50);
		drain_block();

		write_settings(1, int'(UNITY_STEP) + 1);
		queue_random_words(50);
		drain_block();

		repeat (3) begin
			gain = $urandom_range(0, 255);
			step = $urandom_range(0, 1023);
			write_settings(gain, step);
			queue_random_words(50);
			drain_block();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
